[sv/gss_pkg.sv]
// ----------------------------------------------------------------------------
// gss_pkg: shared constants and functions for the glossy specular shade unit
// Fixed-point widths, exp2 bit table, register indexes, log2 table builder.
// ----------------------------------------------------------------------------
package gss_pkg;

   localparam int VECTOR_BITS_DEF = 16;
   localparam int COLOR_BITS_DEF  = 16;
   localparam int LOG_ENTRIES_DEF = 256;

   localparam int Q14_W  = 16;   // internal vector width, Q1.14
   localparam int DMAG_W = 40;   // magnitude of r.wo in Q.28
   localparam int POS_W  = 6;    // msb position of r.wo
   localparam int M_W    = 31;   // exp2 mantissa, Q.30
   localparam int K_W    = 16;   // integer part of the power
   localparam int CSR_IDX_W = 3;

   localparam logic [15:0] GAIN_RESET  = 16'd4096;
   localparam logic [15:0] SHINE_RESET = 16'd2560;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN  = 3'd0,
      CSR_RED   = 3'd1,
      CSR_GREEN = 3'd2,
      CSR_BLUE  = 3'd3,
      CSR_SHINE = 3'd4
   } csr_index_type;

   // 2^(2^-(j+1)) in Q.30
   localparam logic [M_W-1:0] EXP_ROM [16] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280433,
      31'd1097253712, 31'd1085434107, 31'd1079572136, 31'd1076653033,
      31'd1075196444, 31'd1074468888, 31'd1074105295, 31'd1073923544,
      31'd1073832681, 31'd1073787251, 31'd1073764538, 31'd1073753181
   };

   // fraction of log2(x), x in Q.30 within [1,2), by repeated squaring
   function automatic logic [15:0] gss_log2_frac(input logic [63:0] x0);
      logic [63:0] x;
      logic [15:0] res;
      x   = x0;
      res = '0;
      for (int i = 0; i < 16; i++) begin
         x   = (x * x) >> 30;
         res = {res[14:0], 1'b0};
         if (x >= 64'h8000_0000) begin
            res[0] = 1'b1;
            x      = x >> 1;
         end
      end
      return res;
   endfunction

endpackage

[sv/gss_reflect.sv]
// ----------------------------------------------------------------------------
// gss_reflect: reflection of the light direction and dot with the view
// Six stages: convert and n*wi, n.wi, n*(n.wi), r, r*wo, sum and sign.
// ----------------------------------------------------------------------------
module gss_reflect
   import gss_pkg::*;
#(
   parameter int VECTOR_BITS = VECTOR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [VECTOR_BITS-1:0]   vec [9],
   output logic                     out_valid,
   output logic                     out_pos,
   output logic [DMAG_W-1:0]        out_d
);

   logic signed [Q14_W-1:0] q_in [9];

   for (genvar i = 0; i < 9; i++) begin : g_conv
      if (VECTOR_BITS > Q14_W) begin : g_down
         assign q_in[i] = Q14_W'(signed'(vec[i]) >>> (VECTOR_BITS - Q14_W));
      end else begin : g_up
         assign q_in[i] = Q14_W'(signed'(vec[i])) <<< (Q14_W - VECTOR_BITS);
      end
   end

   logic [5:0] vld_ff;

   logic signed [Q14_W-1:0] n1_ff [3], w1_ff [3], o1_ff [3];
   logic signed [31:0]      nw1_ff [3];
   logic signed [Q14_W-1:0] n2_ff [3], w2_ff [3], o2_ff [3];
   logic signed [33:0]      ndot2_ff;
   logic signed [Q14_W-1:0] w3_ff [3], o3_ff [3];
   logic signed [49:0]      t3_ff [3];
   logic signed [Q14_W-1:0] o4_ff [3];
   logic signed [37:0]      r4_ff [3];
   logic signed [53:0]      ro5_ff [3];
   logic                    pos6_ff;
   logic [DMAG_W-1:0]       d6_ff;

   logic signed [55:0]      acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_comb begin
      acc_in = 56'(ro5_ff[0]) + 56'(ro5_ff[1]) + 56'(ro5_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n1_ff[i]  <= q_in[i];
            w1_ff[i]  <= q_in[3+i];
            o1_ff[i]  <= q_in[6+i];
            nw1_ff[i] <= q_in[i] * q_in[3+i];
            n2_ff[i]  <= n1_ff[i];
            w2_ff[i]  <= w1_ff[i];
            o2_ff[i]  <= o1_ff[i];
            w3_ff[i]  <= w2_ff[i];
            o3_ff[i]  <= o2_ff[i];
            t3_ff[i]  <= 50'(n2_ff[i]) * 50'(ndot2_ff);
            o4_ff[i]  <= o3_ff[i];
            // -wi*2^14 + floor(2 n (n.wi) / 2^14)
            r4_ff[i]  <= -(38'(w3_ff[i]) <<< 14) + 38'(t3_ff[i] >>> 13);
            ro5_ff[i] <= 54'(r4_ff[i]) * 54'(o4_ff[i]);
         end
         ndot2_ff <= 34'(nw1_ff[0]) + 34'(nw1_ff[1]) + 34'(nw1_ff[2]);
         pos6_ff  <= !acc_in[55] && (acc_in[55:14] != '0);
         d6_ff    <= acc_in[14 +: DMAG_W];
      end
   end

   assign out_valid = vld_ff[5];
   assign out_pos   = pos6_ff;
   assign out_d     = d6_ff;

endmodule

[sv/gss_power.sv]
// ----------------------------------------------------------------------------
// gss_power: d^shininess as exp2(shininess * log2(d))
// Leading one, normalize, log2 table, exponent multiply, 16 exp2 bit stages.
// ----------------------------------------------------------------------------
module gss_power
   import gss_pkg::*;
#(
   parameter int LOG_TABLE_ENTRIES = LOG_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [15:0]       shininess,
   input  logic              in_valid,
   input  logic              in_pos,
   input  logic [DMAG_W-1:0] in_d,
   output logic              out_valid,
   output logic              out_pos,
   output logic [M_W-1:0]    out_m,
   output logic signed [K_W-1:0] out_k
);

   localparam int IW = (LOG_TABLE_ENTRIES > 1) ? $clog2(LOG_TABLE_ENTRIES) : 1;
   localparam int FW = 30;

   logic [15:0] rom [LOG_TABLE_ENTRIES];
   for (genvar i = 0; i < LOG_TABLE_ENTRIES; i++) begin : g_rom
      localparam logic [63:0] X0 =
         ((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / LOG_TABLE_ENTRIES;
      assign rom[i] = gss_log2_frac(X0);
   end

   logic [3:0] vld_ff;
   logic [3:0] pos_ff;

   logic [DMAG_W-1:0]        d7_ff;
   logic [POS_W-1:0]         p7_ff, p8_ff;
   logic [IW-1:0]            idx8_ff;
   logic signed [22:0]       lg9_ff;
   logic signed [39:0]       pr10_ff;

   logic [POS_W-1:0]         p_in;
   logic [DMAG_W-1:0]        norm_in;
   logic [FW+13-1:0]         idxw_in;

   always_comb begin
      p_in = '0;
      for (int i = 0; i < DMAG_W; i++) begin
         if (in_d[i]) p_in = POS_W'(i);
      end
   end

   always_comb begin
      norm_in = d7_ff << (POS_W'(DMAG_W-1) - p7_ff);
      idxw_in = (FW+13)'(norm_in[DMAG_W-2 -: FW]) * (FW+13)'(LOG_TABLE_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff  <= {pos_ff[2:0], in_pos};
         d7_ff   <= in_d;
         p7_ff   <= p_in;
         p8_ff   <= p7_ff;
         idx8_ff <= IW'(idxw_in >> FW);
         lg9_ff  <= {7'(signed'({1'b0, p8_ff}) - 7'sd28), rom[idx8_ff]};
         pr10_ff <= 40'(lg9_ff) * 40'(signed'({1'b0, shininess}));
      end
   end

   // exp2 bit chain, stage j takes bit 15-j of the fraction
   logic [M_W-1:0]        m_ff [16];
   logic [15:0]           f_ff [16];
   logic signed [K_W-1:0] k_ff [16];
   logic [15:0]           ev_ff, ep_ff;
   logic signed [31:0]    pw_in;

   assign pw_in = 32'(pr10_ff >>> 8);

   for (genvar j = 0; j < 16; j++) begin : g_exp
      logic [M_W-1:0]        m_src;
      logic [15:0]           f_src;
      logic signed [K_W-1:0] k_src;
      logic                  v_src, p_src;
      logic [2*M_W-1:0]      mul;
      if (j == 0) begin : g_first
         assign m_src = M_W'(1) << 30;
         assign f_src = pw_in[15:0];
         assign k_src = pw_in[31:16];
         assign v_src = vld_ff[3];
         assign p_src = pos_ff[3];
      end else begin : g_next
         assign m_src = m_ff[j-1];
         assign f_src = f_ff[j-1];
         assign k_src = k_ff[j-1];
         assign v_src = ev_ff[j-1];
         assign p_src = ep_ff[j-1];
      end
      assign mul = (2*M_W)'(m_src) * (2*M_W)'(EXP_ROM[j]);
      always_ff @(posedge clock) begin
         if (reset) begin
            ev_ff[j] <= 1'b0;
         end else if (en) begin
            ev_ff[j] <= v_src;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[j]  <= f_src[15-j] ? M_W'(mul >> 30) : m_src;
            f_ff[j]  <= f_src;
            k_ff[j]  <= k_src;
            ep_ff[j] <= p_src;
         end
      end
   end

   assign out_valid = ev_ff[15];
   assign out_pos   = ep_ff[15];
   assign out_m     = m_ff[15];
   assign out_k     = k_ff[15];

endmodule

[sv/gss_scale.sv]
// ----------------------------------------------------------------------------
// gss_scale: gain and color scaling with power-of-two shift and saturation
// Two stages: channel multiply, then shift, saturate and output register.
// ----------------------------------------------------------------------------
module gss_scale
   import gss_pkg::*;
#(
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [15:0]           gain,
   input  logic [COLOR_BITS-1:0] color [3],
   input  logic                  in_valid,
   input  logic                  in_pos,
   input  logic [M_W-1:0]        in_m,
   input  logic signed [K_W-1:0] in_k,
   output logic                  out_valid,
   output logic                  out_pos,
   output logic [COLOR_BITS-1:0] out_shade [3]
);

   localparam int GW = COLOR_BITS + 4;
   localparam int PW = COLOR_BITS + 21;
   localparam int VW = COLOR_BITS + 5;
   localparam logic [VW-1:0] MAXV = VW'({COLOR_BITS{1'b1}});

   // config must only change while idle, which the block does not enforce; only then is this registered product current
   logic [GW-1:0] g_ff [3];
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         g_ff[c] <= GW'(((COLOR_BITS+16)'(gain) * (COLOR_BITS+16)'(color[c])) >> 12);
      end
   end

   logic                  v1_ff, v2_ff;
   logic                  p1_ff, p2_ff;
   logic signed [K_W-1:0] k1_ff;
   logic [PW-1:0]         pr1_ff [3];
   logic [COLOR_BITS-1:0] sh2_ff [3];
   logic [COLOR_BITS-1:0] sh_in  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_comb begin
      logic [VW-1:0]  v;
      logic [K_W:0]   nk;
      logic [VW-1:0]  r;
      for (int c = 0; c < 3; c++) begin
         v  = VW'(pr1_ff[c] >> 16);
         nk = -(K_W+1)'(k1_ff);
         r  = '0;
         if (!p1_ff) begin
            r = '0;
         end else if (k1_ff < 0) begin
            if (nk >= (K_W+1)'(VW)) r = '0;
            else r = v >> nk;
         end else if (k1_ff > 0) begin
            if (v == '0) r = '0;
            else if (k1_ff >= K_W'(COLOR_BITS)) r = MAXV;
            else if (v > (MAXV >> k1_ff)) r = MAXV;
            else r = v << k1_ff;
         end else begin
            r = v;
         end
         sh_in[c] = (r > MAXV) ? COLOR_BITS'(MAXV) : COLOR_BITS'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= in_pos;
         k1_ff <= in_k;
         for (int c = 0; c < 3; c++) begin
            pr1_ff[c] <= PW'(g_ff[c]) * PW'(in_m >> 14);
            sh2_ff[c] <= sh_in[c];
         end
         p2_ff <= p1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_pos   = p2_ff;
   assign out_shade = sh2_ff;

endmodule

[sv/glossy_specular_shade_unit.sv]
// ----------------------------------------------------------------------------
// glossy_specular_shade_unit: Phong glossy specular reflectance, fixed point
// Reflects wi about n, dots with wo, raises to shininess, scales per channel.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction | handshake
//  req     | normal, light, view      | in        | req_valid / req_stall
//  rsp     | shade r/g/b, highlight   | out       | rsp_valid / rsp_stall
//  csr     | csr_index, csr_data      | in        | csr_valid / csr_ready
//
// One transaction per cycle unless a held result stalls the pipeline; 6 reflect stages, 20 power
// stages (16 of them one exp2 bit multiply each) and 2 scale stages.
// The whole pipeline advances together; a held result stalls every stage
// and req_stall follows it. Synchronous reset clears all valid bits and
// loads the register defaults. csr_ready is always high.
// ----------------------------------------------------------------------------
module glossy_specular_shade_unit
   import gss_pkg::*;
#(
   parameter int VECTOR_BITS       = VECTOR_BITS_DEF,
   parameter int COLOR_BITS        = COLOR_BITS_DEF,
   parameter int LOG_TABLE_ENTRIES = LOG_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VECTOR_BITS-1:0] req_normal_x,
   input  logic [VECTOR_BITS-1:0] req_normal_y,
   input  logic [VECTOR_BITS-1:0] req_normal_z,
   input  logic [VECTOR_BITS-1:0] req_light_x,
   input  logic [VECTOR_BITS-1:0] req_light_y,
   input  logic [VECTOR_BITS-1:0] req_light_z,
   input  logic [VECTOR_BITS-1:0] req_view_x,
   input  logic [VECTOR_BITS-1:0] req_view_y,
   input  logic [VECTOR_BITS-1:0] req_view_z,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COLOR_BITS-1:0]  rsp_shade_red,
   output logic [COLOR_BITS-1:0]  rsp_shade_green,
   output logic [COLOR_BITS-1:0]  rsp_shade_blue,
   output logic                   rsp_highlight_present,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [((COLOR_BITS > 16) ? COLOR_BITS : 16)-1:0] csr_data
);

   logic [15:0]           gain_ff, shine_ff;
   logic [COLOR_BITS-1:0] color_ff [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         shine_ff <= SHINE_RESET;
         for (int c = 0; c < 3; c++) color_ff[c] <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN:  gain_ff     <= csr_data[15:0];
            CSR_RED:   color_ff[0] <= csr_data[COLOR_BITS-1:0];
            CSR_GREEN: color_ff[1] <= csr_data[COLOR_BITS-1:0];
            CSR_BLUE:  color_ff[2] <= csr_data[COLOR_BITS-1:0];
            CSR_SHINE: shine_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   logic [VECTOR_BITS-1:0] vec [9];
   assign vec = '{req_normal_x, req_normal_y, req_normal_z,
                  req_light_x, req_light_y, req_light_z,
                  req_view_x, req_view_y, req_view_z};

   logic              rf_valid, rf_pos;
   logic [DMAG_W-1:0] rf_d;

   gss_reflect #(.VECTOR_BITS(VECTOR_BITS)) u_reflect (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .vec       (vec),
      .out_valid (rf_valid),
      .out_pos   (rf_pos),
      .out_d     (rf_d)
   );

   logic                  pw_valid, pw_pos;
   logic [M_W-1:0]        pw_m;
   logic signed [K_W-1:0] pw_k;

   gss_power #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_power (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .shininess (shine_ff),
      .in_valid  (rf_valid),
      .in_pos    (rf_pos),
      .in_d      (rf_d),
      .out_valid (pw_valid),
      .out_pos   (pw_pos),
      .out_m     (pw_m),
      .out_k     (pw_k)
   );

   logic [COLOR_BITS-1:0] shade [3];

   gss_scale #(.COLOR_BITS(COLOR_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .gain      (gain_ff),
      .color     (color_ff),
      .in_valid  (pw_valid),
      .in_pos    (pw_pos),
      .in_m      (pw_m),
      .in_k      (pw_k),
      .out_valid (rsp_valid),
      .out_pos   (rsp_highlight_present),
      .out_shade (shade)
   );

   assign rsp_shade_red   = shade[0];
   assign rsp_shade_green = shade[1];
   assign rsp_shade_blue  = shade[2];

endmodule
